[design/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared sizes, request and status codes and address helper for the sorted
// min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DEPTH = 8;
  localparam int DW    = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(2 * DEPTH);
  localparam int REQ_W = 2;
  localparam int ST_W  = 2;
  localparam int OCC_W = 4;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // Circular buffer: logical index relative to head -> RAM address
  function automatic addr_t phys(addr_t head, cnt_t idx);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(idx);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

[design/smpq_ram.sv]
// ----------------------------------------------------------------------------
// smpq_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/smpq_ctrl.sv]
// ----------------------------------------------------------------------------
// smpq_ctrl
// Request sequencer: circular head/count bookkeeping, insertion shift walk,
// remove and list reads, registered result port.
// ----------------------------------------------------------------------------
module smpq_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [smpq_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [smpq_pkg::DW-1:0]    in_value,
  output logic                              out_strobe,
  output logic [smpq_pkg::ST_W-1:0]         out_status,
  output logic signed [smpq_pkg::DW-1:0]    out_data,
  output logic [smpq_pkg::OCC_W-1:0]        out_occupancy,
  output logic                              out_last,
  output logic                              wr_en,
  output smpq_pkg::addr_t                   wr_addr,
  output logic [smpq_pkg::DW-1:0]           wr_data,
  output smpq_pkg::addr_t                   rd_addr,
  input  logic [smpq_pkg::DW-1:0]           rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;

  localparam smpq_pkg::cnt_t ONE = smpq_pkg::cnt_t'(1);

  logic [2:0]                         state_r, state_nxt;
  smpq_pkg::addr_t                    head_r, head_nxt;
  smpq_pkg::cnt_t                     count_r, count_nxt;
  smpq_pkg::cnt_t                     idx_r, idx_nxt;
  logic signed [smpq_pkg::DW-1:0]     val_r, val_nxt;
  logic                               ostb_r, ostb_nxt;
  logic [smpq_pkg::ST_W-1:0]          ost_r, ost_nxt;
  logic signed [smpq_pkg::DW-1:0]     odata_r, odata_nxt;
  logic [smpq_pkg::OCC_W-1:0]         oocc_r, oocc_nxt;
  logic                               olast_r, olast_nxt;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    ostb_nxt  = 1'b0;
    ost_nxt   = smpq_pkg::ST_OK;
    odata_nxt = '0;
    olast_nxt = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = smpq_pkg::phys(head_r, idx_r + ONE);
    wr_data   = rd_data;
    rd_addr   = smpq_pkg::phys(head_r, idx_r - ONE);

    case (state_r)
      S_IDLE: begin
        rd_addr = head_r;
        if (start) begin
          case (in_req_type)
            smpq_pkg::REQ_INSERT: begin
              val_nxt = in_value;
              if (count_r == smpq_pkg::cnt_t'(smpq_pkg::DEPTH)) begin
                ostb_nxt = 1'b1;
                ost_nxt  = smpq_pkg::ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = head_r;
                wr_data   = in_value;
                count_nxt = count_r + ONE;
                ostb_nxt  = 1'b1;
              end else begin
                // walk down from the tail, shifting larger entries up one
                rd_addr   = smpq_pkg::phys(head_r, count_r - ONE);
                idx_nxt   = count_r - ONE;
                state_nxt = S_INS;
              end
            end
            smpq_pkg::REQ_REMOVE: begin
              if (count_r == '0) begin
                ostb_nxt = 1'b1;
                ost_nxt  = smpq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_REM;
              end
            end
            smpq_pkg::REQ_LIST: begin
              if (count_r == '0) begin
                ostb_nxt = 1'b1;
                ost_nxt  = smpq_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        wr_en = 1'b1;
        if ($signed(rd_data) > val_r) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            // next read already issued speculatively
            idx_nxt = idx_r - ONE;
          end
        end else begin
          wr_data   = val_r;
          count_nxt = count_r + ONE;
          ostb_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = val_r;
        count_nxt = count_r + ONE;
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_REM: begin
        odata_nxt = $signed(rd_data);
        head_nxt  = smpq_pkg::phys(head_r, ONE);
        count_nxt = count_r - ONE;
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LIST: begin
        odata_nxt = $signed(rd_data);
        ostb_nxt  = 1'b1;
        olast_nxt = (idx_r == count_r - ONE);
        if (olast_nxt) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr = smpq_pkg::phys(head_r, idx_r + ONE);
          idx_nxt = idx_r + ONE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    oocc_nxt = smpq_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    ost_r   <= ost_nxt;
    odata_r <= odata_nxt;
    oocc_r  <= oocc_nxt;
    olast_r <= olast_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = ostb_r;
  assign out_status    = ost_r;
  assign out_data      = odata_r;
  assign out_occupancy = oocc_r;
  assign out_last      = olast_r;

endmodule

[design/sorted_min_priority_queue.sv]
// Sequence: full/empty answers and insert into an empty queue are answered from idle;
// remove via S_REM; insert walks S_INS past larger entries (S_PUT at head); list via S_LIST.
// Throughput: one transaction at a time, busy held until its last result is registered;
// bounded by the one-read-port RAM walk (one entry per cycle).
// Reset: synchronous active-low rst_n empties the queue; RAM contents are not cleared.
// Results are single-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded min-priority queue kept sorted in a circular RAM buffer.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [smpq_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [smpq_pkg::DW-1:0]    in_value,
  output logic                              out_strobe,
  output logic [smpq_pkg::ST_W-1:0]         out_status,
  output logic signed [smpq_pkg::DW-1:0]    out_data,
  output logic [smpq_pkg::OCC_W-1:0]        out_occupancy,
  output logic                              out_last
);

  logic                      wr_en;
  smpq_pkg::addr_t           wr_addr;
  logic [smpq_pkg::DW-1:0]   wr_data;
  smpq_pkg::addr_t           rd_addr;
  logic [smpq_pkg::DW-1:0]   rd_data;

  smpq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_occupancy (out_occupancy),
    .out_last      (out_last),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  smpq_ram #(
    .WIDTH (smpq_pkg::DW),
    .DEPTH (smpq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef ASSERT_OFF
  // a transaction always finishes with a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_strobe)
    else $error("busy dropped without a result");

  // list results come back to back until the last one
  a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (out_strobe && out_status == smpq_pkg::ST_OK))
    else $error("list burst broken");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == smpq_pkg::ST_FULL) |->
      (out_occupancy == smpq_pkg::OCC_FULL && out_data == '0 && out_last))
    else $error("full status with wrong occupancy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == smpq_pkg::ST_EMPTY) |->
      (out_occupancy == '0 && out_data == '0 && out_last))
    else $error("empty status with non-zero fields");
`endif

endmodule

[test/sorted_min_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_tb
// Drives insert, remove and list requests into the sorted min-priority queue.
// Each result is checked against an in-bench model of the sorted contents.
// A directed run covers the extremes, full, empty and the unused code. A
// random run follows that swings between filling and draining the queue.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_tb;

  localparam logic [smpq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int N_RANDOM    = 380;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [smpq_pkg::ST_W-1:0]      status;
    logic signed [smpq_pkg::DW-1:0] data;
    logic [smpq_pkg::OCC_W-1:0]     occupancy;
    logic                           last;
  } pq_result_t;

  class pq_scoreboard;
    logic signed [smpq_pkg::DW-1:0] held[$];
    pq_result_t                     pending[$];
    int mismatches = 0;
    int checked    = 0;
    int n_full     = 0;
    int n_empty    = 0;
    int n_req[4]   = '{0, 0, 0, 0};

    function void push_result(logic [smpq_pkg::ST_W-1:0] st,
                              logic signed [smpq_pkg::DW-1:0] d, logic l);
      pq_result_t r;
      r.status    = st;
      r.data      = d;
      r.occupancy = smpq_pkg::OCC_W'(held.size());
      r.last      = l;
      pending.push_back(r);
    endfunction

    // Work out what a transaction just accepted must return.
    function void note_request(logic [smpq_pkg::REQ_W-1:0] req,
                               logic signed [smpq_pkg::DW-1:0] val);
      int pos;
      logic signed [smpq_pkg::DW-1:0] smallest;
      n_req[req]++;
      case (req)
        smpq_pkg::REQ_INSERT: begin
          if (held.size() >= smpq_pkg::DEPTH) begin
            n_full++;
            push_result(smpq_pkg::ST_FULL, '0, 1'b1);
          end else begin
            // equal values keep arrival order: go after every entry <= val
            pos = 0;
            while (pos < held.size() && held[pos] <= val) pos++;
            held.insert(pos, val);
            push_result(smpq_pkg::ST_OK, '0, 1'b1);
          end
        end
        smpq_pkg::REQ_REMOVE: begin
          if (held.size() == 0) begin
            n_empty++;
            push_result(smpq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            smallest = held.pop_front();
            push_result(smpq_pkg::ST_OK, smallest, 1'b1);
          end
        end
        smpq_pkg::REQ_LIST: begin
          if (held.size() == 0) begin
            n_empty++;
            push_result(smpq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (held[i]) push_result(smpq_pkg::ST_OK, held[i], i == held.size() - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic signed [63:0] exp_v,
                              logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [smpq_pkg::ST_W-1:0] st,
                               logic signed [smpq_pkg::DW-1:0] d,
                               logic [smpq_pkg::OCC_W-1:0] occ, logic l);
      pq_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d data %0d",
                 $time, st, d);
        return;
      end
      e = pending.pop_front();
      checked++;
      check_field("status", 64'(e.status), 64'(st));
      check_field("data", 64'(e.data), 64'(d));
      check_field("occupancy", 64'(e.occupancy), 64'(occ));
      check_field("last", 64'(e.last), 64'(l));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [smpq_pkg::REQ_W-1:0]     in_req_type;
  logic signed [smpq_pkg::DW-1:0] in_value;
  logic                           out_strobe;
  logic [smpq_pkg::ST_W-1:0]      out_status;
  logic signed [smpq_pkg::DW-1:0] out_data;
  logic [smpq_pkg::OCC_W-1:0]     out_occupancy;
  logic                           out_last;

  pq_scoreboard sb;
  int           cycles = 0;

  sorted_min_priority_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_status, out_data, out_occupancy, out_last);
    end
  end

  // Many small values so duplicates are common, with extremes and full range.
  function automatic logic signed [smpq_pkg::DW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(smpq_pkg::DW-1){1'b0}}};
        1: return {1'b0, {(smpq_pkg::DW-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (r < 5) return smpq_pkg::DW'($urandom_range(0, 15)) - smpq_pkg::DW'(8);
    return $urandom;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic issue_request(logic [smpq_pkg::REQ_W-1:0] req,
                               logic signed [smpq_pkg::DW-1:0] val, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 23) begin
      start       <= 1'b0;
      in_req_type <= smpq_pkg::REQ_W'($urandom);
      in_value    <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    do @(posedge clk); while (busy);
    sb.note_request(req, val);
  endtask

  initial begin
    logic [smpq_pkg::REQ_W-1:0] req;
    int r;
    bit fill_phase;
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = '0;
    in_value    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, duplicates, full, drain
    issue_request(smpq_pkg::REQ_LIST, '0, 1'b1);
    issue_request(smpq_pkg::REQ_REMOVE, '1, 1'b1);
    issue_request(REQ_UNUSED, 32'sd7, 1'b1);
    issue_request(smpq_pkg::REQ_INSERT, 32'sd0, 1'b0);
    issue_request(smpq_pkg::REQ_INSERT, {1'b0, {(smpq_pkg::DW-1){1'b1}}}, 1'b0);
    issue_request(smpq_pkg::REQ_INSERT, {1'b1, {(smpq_pkg::DW-1){1'b0}}}, 1'b1);
    issue_request(smpq_pkg::REQ_INSERT, -32'sd1, 1'b0);
    issue_request(smpq_pkg::REQ_INSERT, 32'sd0, 1'b1);
    issue_request(smpq_pkg::REQ_INSERT, 32'sd1, 1'b0);
    issue_request(smpq_pkg::REQ_INSERT, 32'h5555_5555, 1'b1);
    issue_request(smpq_pkg::REQ_INSERT, 32'hAAAA_AAAA, 1'b0);
    issue_request(smpq_pkg::REQ_INSERT, 32'sd5, 1'b1);
    issue_request(smpq_pkg::REQ_LIST, '1, 1'b0);
    issue_request(REQ_UNUSED, '1, 1'b0);
    repeat (smpq_pkg::DEPTH) issue_request(smpq_pkg::REQ_REMOVE, $urandom, 1'b1);
    issue_request(smpq_pkg::REQ_REMOVE, '0, 1'b0);
    issue_request(smpq_pkg::REQ_LIST, '0, 1'b1);

    // random: alternate fill-biased and drain-biased stretches
    for (int n = 0; n < N_RANDOM; n++) begin
      fill_phase = ((n / 40) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 4) req = REQ_UNUSED;
      else if (r < 19) req = smpq_pkg::REQ_LIST;
      else if (r < (fill_phase ? 75 : 40)) req = smpq_pkg::REQ_INSERT;
      else req = smpq_pkg::REQ_REMOVE;
      issue_request(req, pick_value(), !(n >= 150 && n < 250));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (smpq_pkg::DEPTH + 4) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d lists, %0d unused requests.",
             sb.n_req[smpq_pkg::REQ_INSERT], sb.n_req[smpq_pkg::REQ_REMOVE],
             sb.n_req[smpq_pkg::REQ_LIST], sb.n_req[REQ_UNUSED]);
    $display("Checked %0d results (%0d full, %0d empty), %0d mismatches.",
             sb.checked, sb.n_full, sb.n_empty, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
